>>> src/bjp_pkg.sv
// Package for the block Jacobi preconditioner apply block.
// Holds commands, modes, register indexes, sizes, FSM states and controller/datapath structs.
`default_nettype none
package bjp_pkg;
    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_RECIP = 2'd1,
        CMD_APPLY = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    localparam logic [1:0] MODE_COPY   = 2'd0;
    localparam logic [1:0] MODE_JACOBI = 2'd1;
    localparam logic [1:0] MODE_BLOCK  = 2'd2;

    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_ROWS   = 2'd1;
    localparam logic [1:0] REG_WIDTH  = 2'd2;

    localparam int MAX_ROWS  = 1024;
    localparam int MAX_WIDTH = 8;

    localparam int CFG_W  = 11;
    localparam int VAL_W  = 32;
    localparam int ROW_W  = 10;
    localparam int COL_W  = 3;
    localparam int ACC_W  = 72;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RECIP,
        ST_RD,
        ST_MAC,
        ST_WAIT,
        ST_FIN,
        ST_OUT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic       capture;   // latch input word
        logic       store;     // write coefficient
        logic       recip_go;  // start divider
        logic       recip_step;
        logic       buf_wr;
        logic       acc_clr;
        logic       rd;        // issue coefficient read
        logic       mac;       // accumulate product
        logic       finish;    // round/clip into output reg
        logic       copy;      // output = input value
        logic       jac;       // accumulate single product (Jacobi)
    } t_cmd_bus;
endpackage
`default_nettype wire

>>> src/bjp_if.sv
// Valid/ready stream interface carrying a payload struct.
// Depends on nothing; payload type is a parameter.
`default_nettype none
interface bjp_if #(parameter type T = logic) (input wire logic i_clk);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> src/bjp_div.sv
// Restoring divider for the reciprocal 2^32 / |v|, one quotient bit a cycle.
// Depends on nothing.
`default_nettype none
module bjp_div (
    input  wire logic        i_clk,
    input  wire logic        i_start,
    input  wire logic [31:0] i_value,
    output logic             o_done,
    output logic [31:0]      o_recip
);
    logic [33:0] r_rem;
    logic [33:0] r_quo;
    logic [32:0] r_den;
    logic        r_neg;
    logic        r_zero;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [33:0] trial;
    logic [34:0] q_r;
    logic [34:0] mag_r;

    assign trial = {r_rem[32:0], r_quo[33]};

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg  <= i_value[31];
            r_zero <= (i_value == 32'd0);
            r_den  <= i_value[31] ? (33'd0 - {1'b1, i_value}) : {1'b0, i_value};
            r_rem  <= '0;
            r_quo  <= 34'h1_0000_0000; // dividend 2^32, shifted left each step
            r_cnt  <= 6'd34;
            r_busy <= 1'b1;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_den}) begin
                r_rem <= trial - {1'b0, r_den};
                r_quo <= {r_quo[32:0], 1'b1};
            end else begin
                r_rem <= trial;
                r_quo <= {r_quo[32:0], 1'b0};
            end
            r_cnt <= r_cnt - 6'd1;
            if (r_cnt == 6'd1) r_busy <= 1'b0;
        end
    end

    // round half away: quotient + (2*rem >= den)
    assign o_done = !r_busy;
    always_comb begin
        q_r = {1'b0, r_quo} + {34'd0, ({r_rem, 1'b0} >= {2'b0, r_den})};
        mag_r = q_r;
        if (r_zero) o_recip = 32'd0;
        else if (!r_neg) o_recip = (mag_r > 35'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag_r[31:0];
        else o_recip = (mag_r > 35'h8000_0000) ? 32'h8000_0000 : (32'd0 - mag_r[31:0]);
    end
endmodule
`default_nettype wire

>>> src/bjp_ctrl.sv
// Controller FSM: sequences loads, reciprocal, MAC passes and result emission.
// Depends on bjp_pkg.
`default_nettype none
module bjp_ctrl #(parameter int ROWS_W = 11, parameter int WID_W = 5) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    input  wire logic [1:0]            i_cmd,
    input  wire logic [1:0]            i_mode,
    input  wire logic [ROWS_W-1:0]     i_rows,
    input  wire logic [WID_W-1:0]      i_width,
    input  wire logic                  i_cfg_we,
    input  wire logic                  i_div_done,
    input  wire logic                  i_out_free,
    output logic                       o_in_ready,
    output logic                       o_out_load,
    output bjp_pkg::t_cmd_bus          o_cmd,
    output logic [ROWS_W-1:0]          o_row,    // row of current result
    output logic [WID_W-1:0]           o_l,
    output logic [WID_W-1:0]           o_fill,
    output logic                       o_last,
    output logic                       o_eov
);
    bjp_pkg::t_state r_state, n_state;
    logic [ROWS_W-1:0] r_base, n_base;
    logic [WID_W-1:0]  r_fill, n_fill, r_k, n_k, r_l, n_l, r_w, n_w;
    logic [ROWS_W-1:0] base_eff, left;
    logic [WID_W-1:0]  w_eff;
    logic [1:0]        r_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bjp_pkg::ST_IDLE;
            r_base  <= '0;
            r_fill  <= '0;
            r_k     <= '0;
            r_l     <= '0;
            r_w     <= '0;
            r_mode  <= '0;
        end else begin
            r_state <= n_state;
            r_base  <= i_cfg_we ? '0 : n_base;
            r_fill  <= i_cfg_we ? '0 : n_fill;
            r_k     <= n_k;
            r_l     <= n_l;
            r_w     <= n_w;
            if (o_in_ready && i_in_valid) r_mode <= i_mode;
        end
    end

    always_comb begin
        base_eff = (r_base >= i_rows) ? '0 : r_base;
        left = i_rows - base_eff;
        w_eff = ({{(ROWS_W-WID_W){1'b0}}, i_width} > left) ? left[WID_W-1:0] : i_width;
    end

    assign o_l    = r_l;
    assign o_fill = (r_fill >= w_eff) ? '0 : r_fill;
    assign o_row  = r_base + {{(ROWS_W-WID_W){1'b0}}, r_k};
    assign o_last = (r_k + 1'b1 == r_w);
    assign o_eov  = (o_row + 1'b1 == i_rows);

    always_comb begin
        n_state = r_state;
        n_base = r_base; n_fill = r_fill; n_k = r_k; n_l = r_l; n_w = r_w;
        o_cmd = '0;
        o_in_ready = 1'b0;
        o_out_load = 1'b0;
        unique case (r_state)
            bjp_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    unique case (i_cmd)
                        bjp_pkg::CMD_LOAD: o_cmd.store = 1'b1;
                        bjp_pkg::CMD_RECIP: begin
                            o_cmd.recip_go = 1'b1;
                            n_state = bjp_pkg::ST_RECIP;
                        end
                        bjp_pkg::CMD_APPLY: begin
                            n_base = base_eff;
                            n_k = '0; n_l = '0;
                            o_cmd.acc_clr = 1'b1;
                            if (i_mode == bjp_pkg::MODE_BLOCK) begin
                                o_cmd.buf_wr = 1'b1;
                                n_fill = o_fill + 1'b1;
                                n_w = w_eff;
                                if (o_fill + 1'b1 == w_eff) begin
                                    n_state = bjp_pkg::ST_RD;
                                    n_fill = '0;
                                end
                            end else begin
                                n_w = WID_W'(1);
                                n_state = (i_mode == bjp_pkg::MODE_JACOBI) ?
                                          bjp_pkg::ST_RD : bjp_pkg::ST_FIN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            bjp_pkg::ST_RECIP: begin
                if (i_div_done) begin
                    o_cmd.store = 1'b1;
                    o_cmd.recip_step = 1'b1;
                    n_state = bjp_pkg::ST_IDLE;
                end
            end
            bjp_pkg::ST_RD: begin
                o_cmd.rd = 1'b1;
                n_state = bjp_pkg::ST_MAC;
            end
            bjp_pkg::ST_MAC: begin
                if (r_mode == bjp_pkg::MODE_BLOCK) begin
                    o_cmd.mac = 1'b1;
                    if (r_l + 1'b1 == r_w) n_state = bjp_pkg::ST_WAIT;
                    else begin
                        n_l = r_l + 1'b1;
                        n_state = bjp_pkg::ST_RD;
                    end
                end else begin
                    o_cmd.jac = 1'b1;
                    n_state = bjp_pkg::ST_WAIT;
                end
            end
            // wait state so the last product reaches the accumulator
            bjp_pkg::ST_WAIT: begin
                n_state = bjp_pkg::ST_FIN;
            end
            bjp_pkg::ST_FIN: begin
                if (r_mode != bjp_pkg::MODE_BLOCK && r_mode != bjp_pkg::MODE_JACOBI)
                    o_cmd.copy = 1'b1;
                o_cmd.finish = 1'b1;
                n_state = bjp_pkg::ST_OUT;
            end
            bjp_pkg::ST_OUT: begin
                if (i_out_free) begin
                    o_out_load = 1'b1;
                    o_cmd.acc_clr = 1'b1;
                    n_l = '0;
                    if (o_last) begin
                        n_state = bjp_pkg::ST_IDLE;
                        n_base = (o_row + 1'b1 >= i_rows) ? '0 : o_row + 1'b1;
                    end else begin
                        n_k = r_k + 1'b1;
                        n_state = bjp_pkg::ST_RD;
                    end
                end
            end
            default: n_state = bjp_pkg::ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

>>> src/bjp_dp.sv
// Datapath: coefficient memory, block buffer, MAC with exact accumulation,
// round/saturate. Depends on bjp_pkg and bjp_div.
`default_nettype none
module bjp_dp #(parameter int ROWS_W = 11, parameter int WID_W = 5) (
    input  wire logic              i_clk,
    input  wire bjp_pkg::t_cmd_bus i_cmd,
    input  wire logic [9:0]        i_row,
    input  wire logic [2:0]        i_col,
    input  wire logic [31:0]       i_value,
    input  wire logic [ROWS_W-1:0] i_res_row,
    input  wire logic [WID_W-1:0]  i_l,
    input  wire logic [WID_W-1:0]  i_fill,
    output logic                   o_div_done,
    output logic [31:0]            o_value,
    output logic                   o_sat
);
    localparam int RA_W = (bjp_pkg::MAX_ROWS > 1) ? $clog2(bjp_pkg::MAX_ROWS) : 1;
    localparam int CA_W = (bjp_pkg::MAX_WIDTH > 1) ? $clog2(bjp_pkg::MAX_WIDTH) : 1;
    localparam int DEPTH = bjp_pkg::MAX_ROWS * bjp_pkg::MAX_WIDTH;

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_buf [bjp_pkg::MAX_WIDTH];
    logic [9:0]  r_row;
    logic [2:0]  r_col;
    logic [31:0] r_val;
    logic [31:0] r_coef;
    logic [31:0] r_x;
    logic signed [63:0] r_prod;
    logic signed [bjp_pkg::ACC_W-1:0] r_acc;
    logic        r_pv;
    logic [31:0] recip;
    logic [31:0] wdata;
    logic        in_range;
    logic [RA_W+CA_W-1:0] waddr, raddr;
    logic [ROWS_W-1:0] rrow;
    logic signed [bjp_pkg::ACC_W-1:0] rounded;

    bjp_div u_div (
        .i_clk(i_clk), .i_start(i_cmd.recip_go), .i_value(i_value),
        .o_done(o_div_done), .o_recip(recip)
    );

    always_comb begin
        in_range = ({22'd0, r_row} < bjp_pkg::MAX_ROWS) &&
                   ({29'd0, r_col} < bjp_pkg::MAX_WIDTH);
        waddr = {r_row[RA_W-1:0], r_col[CA_W-1:0]};
        wdata = i_cmd.recip_step ? recip : r_val;
        rrow  = i_res_row;
        raddr = {rrow[RA_W-1:0], i_l[CA_W-1:0]};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_row <= i_row;
            r_col <= i_col;
            r_val <= i_value;
        end
        if (i_cmd.buf_wr) r_buf[i_fill[CA_W-1:0]] <= i_value;
        // immediate load uses the live input; reciprocal uses latched row/col
        if (i_cmd.store && !i_cmd.recip_step) begin
            if (({22'd0, i_row} < bjp_pkg::MAX_ROWS) && ({29'd0, i_col} < bjp_pkg::MAX_WIDTH))
                r_mem[{i_row[RA_W-1:0], i_col[CA_W-1:0]}] <= i_value;
        end else if (i_cmd.store && in_range) begin
            r_mem[waddr] <= wdata;
        end
        if (i_cmd.rd) begin
            r_coef <= r_mem[raddr];
            r_x    <= r_buf[i_l[CA_W-1:0]];
        end
    end

    // product is registered, then accumulated
    always_ff @(posedge i_clk) begin
        r_pv <= i_cmd.mac || i_cmd.jac;
        if (i_cmd.mac)      r_prod <= $signed(r_coef) * $signed(r_x);
        else if (i_cmd.jac) r_prod <= $signed(r_coef) * $signed(r_val);
        if (i_cmd.acc_clr) r_acc <= '0;
        else if (r_pv)     r_acc <= r_acc + {{(bjp_pkg::ACC_W-64){r_prod[63]}}, r_prod};
    end

    // ST_WAIT after the last MAC lets r_pv drain before ST_FIN
    always_comb rounded = (r_acc + 72'sd32768) >>> 16;

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            if (i_cmd.copy) begin
                o_value <= r_val; o_sat <= 1'b0;
            end else if (rounded > 72'sh7FFF_FFFF) begin
                o_value <= 32'h7FFF_FFFF; o_sat <= 1'b1;
            end else if (rounded < -72'sh8000_0000) begin
                o_value <= 32'h8000_0000; o_sat <= 1'b1;
            end else begin
                o_value <= rounded[31:0]; o_sat <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

>>> src/block_jacobi_preconditioner_apply.sv
// Block Jacobi preconditioner apply in Q16.16: copy, diagonal scale or dense block.
// A diagonal load runs the bit-serial reciprocal divider; a block is computed after its
// last element, one row at a time, through the one shared MAC and the single
// coefficient memory read port. Input is taken only while idle, so no new word is
// accepted while a result is in progress. Results leave through an output register.
`default_nettype none
module block_jacobi_preconditioner_apply (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [10:0] i_cfg_data,
    bjp_if.sink              s_in,
    bjp_if.source            m_out
);
    localparam int ROWS_W = $clog2(bjp_pkg::MAX_ROWS + 1) > 11 ?
                            $clog2(bjp_pkg::MAX_ROWS + 1) : 11;
    localparam int WID_W  = 5;

    logic [1:0]  r_mode;
    logic [10:0] r_rows;
    logic [3:0]  r_width;
    logic [ROWS_W-1:0] rows_eff;
    logic [WID_W-1:0]  w_eff;
    logic [1:0]  mode_eff;
    bjp_pkg::t_cmd_bus cmd;
    logic in_ready, out_load, div_done, last, eov, sat;
    logic [ROWS_W-1:0] row;
    logic [WID_W-1:0]  l, fill;
    logic [31:0] val;
    logic r_ov;
    logic [9:0] r_orow;
    logic [31:0] r_oval;
    logic r_olast, r_oeov, r_osat;
    logic cfg_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= '0; r_rows <= 11'd1024; r_width <= 4'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                bjp_pkg::REG_MODE:  r_mode  <= i_cfg_data[1:0];
                bjp_pkg::REG_ROWS:  r_rows  <= i_cfg_data;
                bjp_pkg::REG_WIDTH: r_width <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        rows_eff = (r_rows == 11'd0) ? ROWS_W'(1) :
                   ({{(ROWS_W-11){1'b0}}, r_rows} > ROWS_W'(bjp_pkg::MAX_ROWS)) ?
                   ROWS_W'(bjp_pkg::MAX_ROWS) : {{(ROWS_W-11){1'b0}}, r_rows};
        w_eff = (r_width == 4'd0) ? 5'd1 :
                ({1'b0, r_width} > 5'(bjp_pkg::MAX_WIDTH)) ?
                5'(bjp_pkg::MAX_WIDTH) : {1'b0, r_width};
        // an unknown mode acts as copy
        mode_eff = (r_mode == bjp_pkg::MODE_JACOBI || r_mode == bjp_pkg::MODE_BLOCK) ?
                   r_mode : bjp_pkg::MODE_COPY;
    end

    assign cfg_hit = i_cfg_we && (i_cfg_index == bjp_pkg::REG_MODE ||
                                  i_cfg_index == bjp_pkg::REG_ROWS ||
                                  i_cfg_index == bjp_pkg::REG_WIDTH);

    bjp_ctrl #(.ROWS_W(ROWS_W), .WID_W(WID_W)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(s_in.valid),
        .i_cmd(s_in.data.command), .i_mode(mode_eff),
        .i_rows(rows_eff), .i_width(w_eff), .i_cfg_we(cfg_hit),
        .i_div_done(div_done), .i_out_free(!r_ov || m_out.ready),
        .o_in_ready(in_ready), .o_out_load(out_load), .o_cmd(cmd),
        .o_row(row), .o_l(l), .o_fill(fill), .o_last(last), .o_eov(eov)
    );

    bjp_dp #(.ROWS_W(ROWS_W), .WID_W(WID_W)) u_dp (
        .i_clk(i_clk), .i_cmd(cmd), .i_row(s_in.data.row), .i_col(s_in.data.column),
        .i_value(s_in.data.value), .i_res_row(row), .i_l(l), .i_fill(fill),
        .o_div_done(div_done), .o_value(val), .o_sat(sat)
    );

    assign s_in.ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (out_load) r_ov <= 1'b1;
        else if (m_out.ready) r_ov <= 1'b0;
        if (out_load) begin
            r_orow <= row[9:0]; r_oval <= val; r_olast <= last;
            r_oeov <= eov; r_osat <= sat;
        end
    end

    assign m_out.valid              = r_ov;
    assign m_out.data.out_row       = r_orow;
    assign m_out.data.out_value     = r_oval;
    assign m_out.data.last_of_run   = r_olast;
    assign m_out.data.end_of_vector = r_oeov;
    assign m_out.data.saturated     = r_osat;
endmodule
`default_nettype wire

>>> test/block_jacobi_preconditioner_apply_test.sv
// Testbench for block_jacobi_preconditioner_apply: copy, Jacobi and block Jacobi modes.
// Depends on bjp_pkg and bjp_if; predicts every result word and checks it on the output.
`default_nettype none
module block_jacobi_preconditioner_apply_test;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        bjp_pkg::t_cmd      command;
        logic [9:0]         row;
        logic [2:0]         column;
        logic signed [31:0] value;
    } t_in_word;

    typedef struct packed {
        logic [9:0]         out_row;
        logic signed [31:0] out_value;
        logic               last_of_run;
        logic               end_of_vector;
        logic               saturated;
    } t_out_word;

    localparam int IDLE_LIMIT = 4000;
    localparam longint Q_MAX = 64'sd2147483647;
    localparam longint Q_MIN = -64'sd2147483648;
    // mode code with no meaning of its own
    localparam logic [1:0] MODE_SPARE = 2'd3;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [10:0] i_cfg_data;

    bjp_if #(.T(t_in_word))  in_ch (i_clk);
    bjp_if #(.T(t_out_word)) out_ch (i_clk);

    block_jacobi_preconditioner_apply dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .s_in       (in_ch.sink),
        .m_out      (out_ch.source)
    );

    // predictor state
    logic signed [31:0] coef_mem [0:8191];
    logic signed [31:0] block_buf [0:7];
    logic [1:0]         mode_q;
    logic [10:0]        rows_q;
    logic [3:0]         width_q;
    int unsigned        row_ctr;
    int unsigned        fill_cnt;

    t_out_word expected_words[$];
    int        mismatches;
    int        idle_cycles;
    bit        calm;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned rows_eff();
        if (rows_q == 0) return 1;
        if (rows_q > 1024) return 1024;
        return rows_q;
    endfunction

    function automatic int unsigned width_eff();
        if (width_q == 0) return 1;
        if (width_q > 8) return 8;
        return width_q;
    endfunction

    function automatic string word_str(t_out_word w);
        return $sformatf("row %0d val %h last %b eov %b sat %b", w.out_row, w.out_value,
                         w.last_of_run, w.end_of_vector, w.saturated);
    endfunction

    function automatic logic signed [31:0] recip_q16(logic signed [31:0] v);
        longint mag;
        longint q;
        if (v == 0) return 0;
        mag = (v < 0) ? -longint'(v) : longint'(v);
        q = ((64'sd1 <<< 32) + mag / 2) / mag;
        if (v < 0) q = -q;
        if (q > Q_MAX) q = Q_MAX;
        if (q < Q_MIN) q = Q_MIN;
        return q[31:0];
    endfunction

    // round half up to Q16.16, then clip
    function automatic void round_clip(logic signed [71:0] acc, output logic signed [31:0] res,
                                       output logic sat);
        logic signed [71:0] r;
        r = (acc + 72'sd32768) >>> 16;
        sat = 1'b0;
        if (r > 72'(Q_MAX)) begin
            r = 72'(Q_MAX);
            sat = 1'b1;
        end else if (r < 72'(Q_MIN)) begin
            r = 72'(Q_MIN);
            sat = 1'b1;
        end
        res = r[31:0];
    endfunction

    function automatic void precondition_word(t_in_word w);
        int unsigned rows;
        int unsigned bw;
        int unsigned base;
        logic signed [71:0] acc;
        t_out_word o;
        rows = rows_eff();
        if (w.command == bjp_pkg::CMD_LOAD || w.command == bjp_pkg::CMD_RECIP) begin
            coef_mem[{w.row, w.column}] = (w.command == bjp_pkg::CMD_LOAD) ?
                                          w.value : recip_q16(w.value);
            return;
        end
        if (w.command != bjp_pkg::CMD_APPLY) return;
        if (row_ctr >= rows) row_ctr = 0;
        if (mode_q == bjp_pkg::MODE_BLOCK) begin
            bw = width_eff();
            base = row_ctr;
            if (bw > rows - base) bw = rows - base;
            if (fill_cnt >= bw) fill_cnt = 0;
            block_buf[fill_cnt] = w.value;
            fill_cnt++;
            if (fill_cnt < bw) return;
            for (int k = 0; k < bw; k++) begin
                acc = 0;
                for (int l = 0; l < bw; l++)
                    acc += 72'(longint'(coef_mem[(base + k) * 8 + l]) * longint'(block_buf[l]));
                o.out_row = 10'(base + k);
                round_clip(acc, o.out_value, o.saturated);
                o.last_of_run = (k + 1 == bw);
                o.end_of_vector = (base + k + 1 == rows);
                expected_words.push_back(o);
            end
            fill_cnt = 0;
            row_ctr = (base + bw >= rows) ? 0 : base + bw;
        end else begin
            o.out_row = 10'(row_ctr);
            if (mode_q == bjp_pkg::MODE_JACOBI) begin
                acc = 72'(longint'(coef_mem[row_ctr * 8]) * longint'(w.value));
                round_clip(acc, o.out_value, o.saturated);
            end else begin
                o.out_value = w.value;
                o.saturated = 1'b0;
            end
            o.last_of_run = 1'b1;
            o.end_of_vector = (row_ctr + 1 == rows);
            expected_words.push_back(o);
            row_ctr = (row_ctr + 1 >= rows) ? 0 : row_ctr + 1;
        end
    endfunction

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return $urandom_range(0, 1) ? 32'sh0001_0000 : -32'sh0001_0000;
            3: return $signed($urandom_range(0, 32'h3_ffff)) - 32'sh2_0000;
            default: return $urandom;
        endcase
    endfunction

    // entered at a rising edge; returns at the edge where the word is accepted
    task automatic send_word(bjp_pkg::t_cmd cmd, logic [9:0] row, logic [2:0] col,
                             logic signed [31:0] val);
        t_in_word w;
        bit rdy;
        if (!calm && $urandom_range(0, 4) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        w.command = cmd;
        w.row = row;
        w.column = col;
        w.value = val;
        in_ch.valid <= 1'b1;
        in_ch.data <= w;
        forever begin
            @(negedge i_clk);
            rdy = in_ch.ready;
            @(posedge i_clk);
            if (rdy) break;
        end
        precondition_word(w);
    endtask

    // drop valid, wait for every expected word, then let a diagonal load finish
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_regs(logic [1:0] mode, logic [10:0] rows, logic [3:0] bw);
        i_cfg_we <= 1'b1;
        i_cfg_index <= bjp_pkg::REG_MODE;
        i_cfg_data <= 11'(mode);
        @(posedge i_clk);
        i_cfg_index <= bjp_pkg::REG_ROWS;
        i_cfg_data <= rows;
        @(posedge i_clk);
        i_cfg_index <= bjp_pkg::REG_WIDTH;
        i_cfg_data <= 11'(bw);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        mode_q = mode;
        rows_q = rows;
        width_q = bw;
        row_ctr = 0;
        fill_cnt = 0;
    endtask

    // fill the coefficients that applies over the first nrows rows will read
    task automatic preload(int unsigned nrows, int unsigned ncols);
        for (int r = 0; r < nrows; r++)
            for (int c = 0; c < ncols; c++)
                send_word($urandom_range(0, 3) == 0 ? bjp_pkg::CMD_RECIP : bjp_pkg::CMD_LOAD,
                          10'(r), 3'(c), pick_value());
    endtask

    task automatic test_copy();
        write_regs(bjp_pkg::MODE_COPY, 11'd5, 4'd1);
        send_word(bjp_pkg::CMD_APPLY, 10'd1023, 3'd7, 32'sh8000_0000);
        send_word(bjp_pkg::CMD_APPLY, 10'd0, 3'd0, 32'sh7fff_ffff);
        send_word(bjp_pkg::CMD_NONE, 10'd3, 3'd2, 32'sh1234_5678);
        send_word(bjp_pkg::CMD_APPLY, 10'd0, 3'd0, 32'sh0);
        send_word(bjp_pkg::CMD_APPLY, 10'd0, 3'd0, -32'sh1);
        send_word(bjp_pkg::CMD_APPLY, 10'd0, 3'd0, 32'sh0001_0000);
        send_word(bjp_pkg::CMD_APPLY, 10'd0, 3'd0, 32'sh5555_aaaa);
        drain();
    endtask

    task automatic test_jacobi();
        write_regs(bjp_pkg::MODE_JACOBI, 11'd6, 4'd1);
        send_word(bjp_pkg::CMD_LOAD, 10'd0, 3'd0, 32'sh7fff_ffff);
        send_word(bjp_pkg::CMD_LOAD, 10'd1, 3'd0, 32'sh8000_0000);
        send_word(bjp_pkg::CMD_RECIP, 10'd2, 3'd0, 32'sh0);
        send_word(bjp_pkg::CMD_RECIP, 10'd3, 3'd0, 32'sh1);
        send_word(bjp_pkg::CMD_RECIP, 10'd4, 3'd0, -32'sh1);
        send_word(bjp_pkg::CMD_RECIP, 10'd5, 3'd0, 32'sh0003_0000);
        send_word(bjp_pkg::CMD_RECIP, 10'd1023, 3'd7, 32'sh8000_0000);
        send_word(bjp_pkg::CMD_APPLY, 10'd0, 3'd0, 32'sh7fff_ffff);
        send_word(bjp_pkg::CMD_APPLY, 10'd0, 3'd0, 32'sh7fff_ffff);
        send_word(bjp_pkg::CMD_APPLY, 10'd0, 3'd0, 32'sh1234_5678);
        send_word(bjp_pkg::CMD_APPLY, 10'd0, 3'd0, 32'sh0000_8000);
        send_word(bjp_pkg::CMD_APPLY, 10'd0, 3'd0, -32'sh0000_8000);
        send_word(bjp_pkg::CMD_APPLY, 10'd0, 3'd0, 32'sh0002_0000);
        drain();
    endtask

    task automatic test_block_partial();
        // six rows in blocks of four: the last block is two rows wide
        write_regs(bjp_pkg::MODE_BLOCK, 11'd6, 4'd4);
        preload(6, 4);
        for (int i = 0; i < 8; i++) send_word(bjp_pkg::CMD_APPLY, 10'd0, 3'd0, pick_value());
        // a load between elements leaves the buffered block intact
        send_word(bjp_pkg::CMD_APPLY, 10'd0, 3'd0, pick_value());
        send_word(bjp_pkg::CMD_LOAD, 10'd900, 3'd5, pick_value());
        for (int i = 0; i < 4; i++) send_word(bjp_pkg::CMD_APPLY, 10'd0, 3'd0, pick_value());
        // leave a block half-filled; the register writes of the next test drop it
        for (int i = 0; i < 2; i++) send_word(bjp_pkg::CMD_APPLY, 10'd0, 3'd0, pick_value());
        drain();
    endtask

    task automatic test_register_extremes();
        write_regs(MODE_SPARE, 11'd0, 4'd0);
        for (int i = 0; i < 3; i++) send_word(bjp_pkg::CMD_APPLY, 10'd0, 3'd0, pick_value());
        drain();
        write_regs(bjp_pkg::MODE_BLOCK, 11'd2047, 4'd15);
        preload(16, 8);
        for (int i = 0; i < 16; i++) send_word(bjp_pkg::CMD_APPLY, 10'd0, 3'd0, pick_value());
        drain();
        write_regs(bjp_pkg::MODE_BLOCK, 11'd1, 4'd8);
        for (int i = 0; i < 3; i++) send_word(bjp_pkg::CMD_APPLY, 10'd0, 3'd0, pick_value());
        drain();
    endtask

    task automatic test_random(int phases, int per_phase);
        int unsigned reach;
        int unsigned ncols;
        int unsigned r;
        int unsigned c;
        logic [10:0] rows;
        for (int p = 0; p < phases; p++) begin
            case ($urandom_range(0, 5))
                0: rows = 11'($urandom_range(1030, 2047));
                1: rows = 11'd0;
                default: rows = 11'($urandom_range(1, 24));
            endcase
            write_regs(2'($urandom_range(0, 3)), rows, 4'($urandom_range(0, 15)));
            reach = rows_eff();
            if (reach > per_phase + 8) reach = per_phase + 8;
            ncols = (mode_q == bjp_pkg::MODE_BLOCK) ? width_eff() : 1;
            if (mode_q == bjp_pkg::MODE_JACOBI || mode_q == bjp_pkg::MODE_BLOCK)
                preload(reach, ncols);
            for (int i = 0; i < per_phase; i++) begin
                case ($urandom_range(0, 9))
                    0: begin
                        r = $urandom_range(0, 1023);
                        c = $urandom_range(0, 7);
                        send_word($urandom_range(0, 1) ? bjp_pkg::CMD_RECIP : bjp_pkg::CMD_LOAD,
                                  10'(r), 3'(c), pick_value());
                    end
                    1: send_word(bjp_pkg::CMD_NONE, 10'($urandom), 3'($urandom), $urandom);
                    default: send_word(bjp_pkg::CMD_APPLY, 10'($urandom), 3'($urandom),
                                       pick_value());
                endcase
            end
            drain();
        end
    endtask

    // result checker and watchdog, sampled away from the driving edge
    always @(negedge i_clk) begin
        t_out_word exp_w;
        t_out_word got;
        if (i_rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > IDLE_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
            if (out_ch.valid && out_ch.ready) begin
                got = out_ch.data;
                if (expected_words.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word: %s", word_str(got));
                end else begin
                    exp_w = expected_words.pop_front();
                    if (got.out_row !== exp_w.out_row || got.out_value !== exp_w.out_value
                        || got.last_of_run !== exp_w.last_of_run
                        || got.end_of_vector !== exp_w.end_of_vector
                        || got.saturated !== exp_w.saturated) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp %s, got %s", word_str(exp_w),
                                     word_str(got));
                    end
                end
            end
        end
    end

    // output stalls in random bursts, none once calm
    initial begin
        out_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (calm || $urandom_range(0, 3) != 0) begin
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
                out_ch.ready <= 1'b1;
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = bjp_pkg::REG_MODE;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        mismatches = 0;
        idle_cycles = 0;
        calm = 1'b0;
        mode_q = bjp_pkg::MODE_COPY;
        rows_q = 11'd1024;
        width_q = 4'd1;
        row_ctr = 0;
        fill_cnt = 0;
        for (int i = 0; i < 8192; i++) coef_mem[i] = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (60) @(posedge i_clk);

        test_copy();
        test_jacobi();
        test_block_partial();
        test_register_extremes();
        test_random(3, 20);
        calm = 1'b1;
        test_random(1, 20);

        drain();
        if (mismatches == 0 && expected_words.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
`default_nettype wire
